// File: hdl/lie_pkg.sv
// Package for the instruction executor: request and result item types,
// opcodes, decoded-instruction type and default sizes. No dependencies.
`timescale 1ns / 1ps
package lie_pkg;

	localparam int MemDepthDefault = 1024;
	localparam int DataWidthDefault = 32;
	localparam int RegCount = 8;
	localparam int RegIdxW = 3;

	localparam logic [RegIdxW-1:0] IMM_REG = 3'd1;
	localparam logic [RegIdxW-1:0] LINK_REG = 3'd7;

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_LSF = 5'd2;
	localparam logic [4:0] OP_RSF = 5'd3;
	localparam logic [4:0] OP_AND = 5'd4;
	localparam logic [4:0] OP_OR = 5'd5;
	localparam logic [4:0] OP_XOR = 5'd6;
	localparam logic [4:0] OP_LHI = 5'd7;
	localparam logic [4:0] OP_LD = 5'd8;
	localparam logic [4:0] OP_ST = 5'd9;
	localparam logic [4:0] OP_JLT = 5'd16;
	localparam logic [4:0] OP_JLE = 5'd17;
	localparam logic [4:0] OP_JEQ = 5'd18;
	localparam logic [4:0] OP_JNE = 5'd19;
	localparam logic [4:0] OP_JIN = 5'd20;
	localparam logic [4:0] OP_HLT = 5'd24;

	typedef struct packed {
		logic [4:0] req_type;
		logic [2:0] dest_index;
		logic [2:0] first_source;
		logic [2:0] second_source;
		logic signed [31:0] immediate;
	} lie_req_t;

	typedef struct packed {
		logic [9:0] next_pc;
		logic running;
		logic reg_written;
		logic [2:0] written_index;
		logic signed [31:0] written_value;
		logic mem_written;
	} lie_rsp_t;

	// Instruction as classified by the front end.
	typedef struct packed {
		logic [4:0] op;
		logic [2:0] rd;
		logic [2:0] ra;
		logic [2:0] rb;
		logic [31:0] imm;
		logic sel_imm;
		logic is_load;
	} lie_op_t;

endpackage

// File: hdl/lie_front.sv
// Front end: accepts request items, classifies them and holds them in a
// two-entry queue for the back end. Depends on lie_pkg.
`timescale 1ns / 1ps
module lie_front import lie_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input lie_req_t req,
	input logic hold,
	output logic head_valid,
	output lie_op_t head,
	input logic pop
);

	lie_op_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	lie_op_t dec;

	always_comb begin
		dec.op = req.req_type;
		dec.rd = req.dest_index;
		dec.ra = req.first_source;
		dec.rb = req.second_source;
		dec.imm = req.immediate;
		dec.sel_imm = (req.first_source == IMM_REG) || (req.second_source == IMM_REG);
		dec.is_load = (req.req_type == OP_LD);
	end

	assign req_stall = (count_q == 2'd2) || hold;
	assign push = req_valid && !req_stall;
	assign head_valid = (count_q != 2'd0);
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: hdl/lie_back.sv
// Back end: register file, data memory, program counter and result register.
// Executes the queue head. Depends on lie_pkg.
`timescale 1ns / 1ps
module lie_back import lie_pkg::*; #(
	parameter int MEM_DEPTH = MemDepthDefault,
	parameter int DATA_WIDTH = DataWidthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input lie_op_t head,
	output logic pop,
	output logic clearing,
	output logic rsp_valid,
	input logic rsp_stall,
	output lie_rsp_t rsp
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int DW = DATA_WIDTH;

	logic [DW-1:0] rf_q [RegCount];
	logic [DW-1:0] mem [MEM_DEPTH];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] pc_q;
	logic run_q;
	logic ld_pend_q;
	logic [AW:0] clr_q;
	logic rsp_valid_q;
	lie_rsp_t rsp_q;

	logic [DW-1:0] imm_dw, a, b, r1, rdv, res, wval;
	logic wr, mw, jmp, cond, taken, run_n, out_ready, fire, issue;
	logic [AW-1:0] pc_n;
	logic [2:0] widx;

	assign clearing = !clr_q[AW];
	assign out_ready = !rsp_valid_q || !rsp_stall;
	assign issue = head_valid && head.is_load && !ld_pend_q;
	assign fire = head_valid && out_ready && (!head.is_load || ld_pend_q);
	assign pop = fire;

	always_comb begin
		imm_dw = DW'($signed(head.imm));
		r1 = head.sel_imm ? imm_dw : rf_q[IMM_REG];
		a = (head.ra == IMM_REG && head.sel_imm) ? imm_dw : rf_q[head.ra];
		b = (head.rb == IMM_REG && head.sel_imm) ? imm_dw : rf_q[head.rb];
		rdv = (head.rd == IMM_REG && head.sel_imm) ? imm_dw : rf_q[head.rd];
		res = '0;
		wr = 1'b0;
		mw = 1'b0;
		jmp = 1'b0;
		cond = 1'b0;
		run_n = run_q;
		case (head.op)
			OP_ADD: begin res = a + b; wr = 1'b1; end
			OP_SUB: begin res = a - b; wr = 1'b1; end
			OP_LSF: begin res = (b >= DW) ? '0 : (a << b); wr = 1'b1; end
			OP_RSF: begin res = (b >= DW) ? '0 : (a >> b); wr = 1'b1; end
			OP_AND: begin res = a & b; wr = 1'b1; end
			OP_OR: begin res = a | b; wr = 1'b1; end
			OP_XOR: begin res = a ^ b; wr = 1'b1; end
			OP_LHI: begin res = (rdv & DW'(32'h0000ffff)) | (r1 << 16); wr = 1'b1; end
			OP_LD: begin res = rdata_q; wr = 1'b1; end
			OP_ST: begin mw = 1'b1; end
			OP_JLT: begin jmp = 1'b1; cond = $signed(a) < $signed(b); end
			OP_JLE: begin jmp = 1'b1; cond = !($signed(b) < $signed(a)); end
			OP_JEQ: begin jmp = 1'b1; cond = (a == b); end
			OP_JNE: begin jmp = 1'b1; cond = (a != b); end
			OP_JIN: begin jmp = 1'b1; cond = 1'b1; end
			OP_HLT: begin run_n = 1'b0; end
			default: begin end
		endcase
		taken = jmp && cond;
		widx = taken ? LINK_REG : (wr ? head.rd : 3'd0);
		wval = taken ? DW'(pc_q) : (wr ? res : '0);
		pc_n = taken ? r1[AW-1:0] : pc_q + 1'b1;
	end

	// The data memory is swept to zero after reset, one word per cycle.
	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (fire && mw) begin
			mem[b[AW-1:0]] <= a;
		end
		if (issue) begin
			rdata_q <= mem[b[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) begin
				rf_q[i] <= '0;
			end
			pc_q <= '0;
			run_q <= 1'b1;
			ld_pend_q <= 1'b0;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (issue) begin
				ld_pend_q <= 1'b1;
			end
			if (fire) begin
				ld_pend_q <= 1'b0;
				if (head.sel_imm) begin
					rf_q[IMM_REG] <= imm_dw;
				end
				if (wr) begin
					rf_q[head.rd] <= res;
				end
				if (taken) begin
					rf_q[LINK_REG] <= DW'(pc_q);
				end
				pc_q <= pc_n;
				run_q <= run_n;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.next_pc <= 10'(pc_n);
			rsp_q.running <= run_n;
			rsp_q.reg_written <= wr || taken;
			rsp_q.written_index <= widx;
			rsp_q.written_value <= 32'(wval);
			rsp_q.mem_written <= mw;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// File: hdl/lab_isa_instruction_executor.sv
// Instruction executor, top level: joins the front end queue and the back end.
// Depends on lie_pkg, lie_front and lie_back.
//
// Usage: decoded instructions enter on the req channel (req_valid, req_stall,
// req) and one result item per instruction leaves on the rsp channel
// (rsp_valid, rsp_stall, rsp) in program order.
// rsp_valid rises once an accepted item has passed the queue and the back
// end has registered its result. Throughput is one item per cycle while
// rsp_stall is low; a load holds the back end until its data memory read,
// whose port is registered, returns. A two-entry queue sits between the front
// end and the back end, so the input keeps accepting items while a result
// waits in the output register. After reset the register file and PC are
// cleared and the run flag is set at once, while the data memory is swept to
// zero word by word (MEM_DEPTH words, 1024 by default); req_stall stays high for that time.
// When the receiver stalls, the result holds in the output register, the
// back end stops and the queue fills, after which req_stall rises.
`timescale 1ns / 1ps
module lab_isa_instruction_executor import lie_pkg::*; #(
	parameter int MEM_DEPTH = MemDepthDefault,
	parameter int DATA_WIDTH = DataWidthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input lie_req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output lie_rsp_t rsp
);

	logic head_valid;
	lie_op_t head;
	logic pop;
	logic clearing;

	lie_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.hold(clearing),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	lie_back #(
		.MEM_DEPTH(MEM_DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.clearing(clearing),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
